/* rtl/core/quat_to_rotation_matrix_core_assert.svh */
// Assertion macros for the quaternion to rotation matrix core
`ifndef QUAT_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define QUAT_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define Q2R_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2r check failed");
// Next-cycle implication checked outside reset
`define Q2R_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2r check failed");
`endif

/* rtl/core/q2r_pkg.sv */
// Package: shared widths and types for the quaternion to rotation matrix core
package q2r_pkg;
  localparam int OUT_W = 16;
  localparam int NUM_ENT = 9;
  typedef logic signed [OUT_W-1:0] ent_t;
  typedef ent_t [NUM_ENT-1:0] mat_t;
endpackage

/* rtl/core/quat_to_rotation_matrix_core.sv */
// Top level: pipelined quaternion to rotation matrix converter
// Usage:
//   in_tdata carries one quaternion (w, x, y, z), IN_WIDTH bits each, two's
//   complement, any common scale. out_tdata carries the nine entries of the
//   rotation matrix of the normalized quaternion in signed fixed point with
//   FRAC_BITS fraction bits, rounded to nearest and saturated to +-1.0.
//   out_tuser is 1 for an all-zero quaternion, whose entries are then zero.
// Pipeline: two product/numerator stages, an integer-part stage,
//   FRAC_BITS+2 division steps and one rounding stage.
// Throughput: one item per cycle while the output is not stalled; the
//   divider is a chain of restoring steps, one quotient bit per stage,
//   all nine entries side by side.
// Reset clears every valid bit; payload registers hold garbage until filled.
// Stall: the whole pipeline advances only while the output register is
//   empty or being taken, so a stalled receiver freezes all stages and
//   nothing is lost or repeated.
`include "quat_to_rotation_matrix_core_assert.svh"
module quat_to_rotation_matrix_core import q2r_pkg::*; #(
  parameter int IN_WIDTH = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // q_scalar, q_x, q_y, q_z from the lowest bit up
  input  logic [4*IN_WIDTH-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  output logic [NUM_ENT*OUT_W-1:0] out_tdata,
  // zero_input
  output logic                  out_tuser
);
  localparam int NUM_W = 2*IN_WIDTH+3;
  localparam int STEPS = FRAC_BITS + 2;
  localparam int Q_W = FRAC_BITS + 3;
  // stage count: 2 product stages, 1 integer stage, STEPS divide, 1 output
  localparam int NSTG = STEPS + 4;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic adv;
  logic [NSTG-1:0] zero_r;
  logic [NUM_ENT-1:0] neg_d_r [NSTG];

  // advance the whole chain when the output slot is free or being drained
  assign adv = !vld_r[NSTG-1] || out_tready;
  assign in_tready = adv;

  always_comb begin
    vld_nxt = {vld_r[NSTG-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // zero flag and signs travel beside the data
  logic zero_in;
  assign zero_in = (in_tdata == '0);
  logic [NUM_ENT-1:0] neg_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= {zero_r[NSTG-2:0], zero_in};
      neg_d_r[0] <= '0;
      neg_d_r[1] <= '0;
      neg_d_r[2] <= neg_p;
      for (int i = 3; i < NSTG; i++) neg_d_r[i] <= neg_d_r[i-1];
    end
  end

  logic [NUM_W-1:0] mag [NUM_ENT];
  logic [NUM_W-1:0] norm;

  q2r_prod #(.IN_WIDTH(IN_WIDTH), .NUM_W(NUM_W)) u_prod (
    .clk(clk), .en(adv),
    .w(in_tdata[IN_WIDTH-1:0]), .x(in_tdata[2*IN_WIDTH-1:IN_WIDTH]),
    .y(in_tdata[3*IN_WIDTH-1:2*IN_WIDTH]), .z(in_tdata[4*IN_WIDTH-1:3*IN_WIDTH]),
    .mag_o(mag), .neg_o(neg_p), .norm_o(norm)
  );

  // integer part stage: diagonal magnitudes never exceed the norm,
  // off-diagonal ones never exceed half of it
  logic [NUM_W-1:0] rem_c [STEPS+1][NUM_ENT];
  logic [Q_W-1:0] q_c [STEPS+1][NUM_ENT];
  logic [NUM_W-1:0] den_c [STEPS+1];
  logic [NUM_W-1:0] rem0_r [NUM_ENT];
  logic [Q_W-1:0] q0_r [NUM_ENT];
  logic [NUM_W-1:0] den0_r;
  logic [NUM_W-1:0] ip_rem [NUM_ENT];
  logic [Q_W-1:0] ip_q [NUM_ENT];

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      if (mag[i] >= norm && norm != '0) begin
        ip_rem[i] = mag[i] - norm;
        ip_q[i] = Q_W'(1);
      end else begin
        ip_rem[i] = mag[i];
        ip_q[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem0_r <= ip_rem;
      q0_r <= ip_q;
      den0_r <= norm;
    end
  end

  assign rem_c[0] = rem0_r;
  assign q_c[0] = q0_r;
  assign den_c[0] = den0_r;

  // every entry runs STEPS steps: an off-diagonal half numerator a gives
  // floor(a * 2^STEPS / n), the entry in FRAC_BITS+1 fraction bits; a
  // diagonal numerator gets one fraction bit more than that and is halved later
  for (genvar s = 0; s < STEPS; s++) begin : g_div
    q2r_div_stage #(.NUM_W(NUM_W), .Q_W(Q_W)) u_stage (
      .clk(clk), .en(adv),
      .rem_i(rem_c[s]), .q_i(q_c[s]), .den_i(den_c[s]),
      .rem_o(rem_c[s+1]), .q_o(q_c[s+1]), .den_o(den_c[s+1])
    );
  end

  // round, saturate and sign; diagonals took one step too many, so halve
  // their quotient first
  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;
  mat_t res_nxt, res_r;
  logic [Q_W-1:0] q2, mg;

  always_comb begin
    q2 = '0;
    mg = '0;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (i == 0 || i == 4 || i == 8) q2 = q_c[STEPS][i] >> 1;
      else q2 = q_c[STEPS][i];
      mg = (q2 + Q_W'(1)) >> 1;
      if (mg > ONE) mg = ONE;
      if (zero_r[NSTG-2]) mg = '0;
      res_nxt[i] = neg_d_r[NSTG-2][i] ? OUT_W'(-mg) : OUT_W'(mg);
    end
  end

  logic zero_out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      zero_out_r <= zero_r[NSTG-2];
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata = res_r;
  assign out_tuser = zero_out_r;

  `Q2R_ASSERT_IMP(a_stall_hold, out_tvalid && !out_tready, !in_tready)
  `Q2R_ASSERT_NXT(a_zero_out, out_tvalid && out_tuser && out_tready == 1'b0,
                  out_tvalid && out_tuser)
  `Q2R_ASSERT_IMP(a_zero_ent, out_tvalid && out_tuser, out_tdata == '0)
endmodule

/* rtl/core/q2r_prod.sv */
// Products and numerators: two register stages from quaternion to entry magnitudes
module q2r_prod import q2r_pkg::*; #(
  parameter int IN_WIDTH = 16,
  parameter int NUM_W = 2*IN_WIDTH+3
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [IN_WIDTH-1:0]  w,
  input  logic signed [IN_WIDTH-1:0]  x,
  input  logic signed [IN_WIDTH-1:0]  y,
  input  logic signed [IN_WIDTH-1:0]  z,
  output logic [NUM_W-1:0]            mag_o [NUM_ENT],
  output logic [NUM_ENT-1:0]          neg_o,
  output logic [NUM_W-1:0]            norm_o
);
  localparam int PW = 2*IN_WIDTH;
  logic signed [PW-1:0] p_r [10];
  logic signed [PW-1:0] p_nxt [10];
  logic signed [NUM_W-1:0] num [NUM_ENT];
  logic signed [NUM_W-1:0] e [10];
  logic [NUM_W-1:0] mag_r [NUM_ENT];
  logic [NUM_ENT-1:0] neg_r;
  logic [NUM_W-1:0] norm_r;

  always_comb begin
    // ww xx yy zz xy xz yz wx wy wz
    p_nxt[0] = w*w; p_nxt[1] = x*x; p_nxt[2] = y*y; p_nxt[3] = z*z;
    p_nxt[4] = x*y; p_nxt[5] = x*z; p_nxt[6] = y*z;
    p_nxt[7] = w*x; p_nxt[8] = w*y; p_nxt[9] = w*z;
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end

  always_comb begin
    for (int i = 0; i < 10; i++) e[i] = NUM_W'(p_r[i]);
    // diagonal: full numerator; off-diagonal: half numerator, the divider
    // steps account for the factor of two
    num[0] = e[0] + e[1] - e[2] - e[3];
    num[4] = e[0] - e[1] + e[2] - e[3];
    num[8] = e[0] - e[1] - e[2] + e[3];
    num[1] = e[4] - e[9];
    num[2] = e[5] + e[8];
    num[3] = e[4] + e[9];
    num[5] = e[6] - e[7];
    num[6] = e[5] - e[8];
    num[7] = e[6] + e[7];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        neg_r[i] <= num[i][NUM_W-1];
        mag_r[i] <= num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
      end
      norm_r <= NUM_W'(e[0] + e[1] + e[2] + e[3]);
    end
  end

  assign mag_o = mag_r;
  assign neg_o = neg_r;
  assign norm_o = norm_r;
endmodule

/* rtl/core/q2r_div_stage.sv */
// One restoring-division step for all nine entries
module q2r_div_stage import q2r_pkg::*; #(
  parameter int NUM_W = 35,
  parameter int Q_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  rem_i [NUM_ENT],
  input  logic [Q_W-1:0]    q_i [NUM_ENT],
  input  logic [NUM_W-1:0]  den_i,
  output logic [NUM_W-1:0]  rem_o [NUM_ENT],
  output logic [Q_W-1:0]    q_o [NUM_ENT],
  output logic [NUM_W-1:0]  den_o
);
  logic [NUM_W:0] sh [NUM_ENT];
  logic [NUM_W-1:0] rem_nxt [NUM_ENT];
  logic [Q_W-1:0] q_nxt [NUM_ENT];
  logic [NUM_W-1:0] rem_r [NUM_ENT];
  logic [Q_W-1:0] q_r [NUM_ENT];
  logic [NUM_W-1:0] den_r;

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      sh[i] = {rem_i[i], 1'b0};
      if (sh[i] >= {1'b0, den_i}) begin
        rem_nxt[i] = NUM_W'(sh[i] - {1'b0, den_i});
        q_nxt[i] = {q_i[i][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = sh[i][NUM_W-1:0];
        q_nxt[i] = {q_i[i][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r <= q_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign q_o = q_r;
  assign den_o = den_r;
endmodule

/* sim/tb_quat_to_rotation_matrix_core.sv */
// Testbench for the quaternion to rotation matrix core: random, directed and backpressure tests
`timescale 1ns / 100ps
module tb_quat_to_rotation_matrix_core;
  import q2r_pkg::*;

  localparam int IN_W = 16;
  localparam int FB = 14;
  localparam int LATENCY = FB + 6;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [IN_W-1:0] qz;
    logic signed [IN_W-1:0] qy;
    logic signed [IN_W-1:0] qx;
    logic signed [IN_W-1:0] qw;
  } quat_t;

  typedef struct {
    mat_t m;
    logic zero;
  } rot_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // q_scalar, q_x, q_y, q_z from the lowest bit up
  logic [4*IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // m_r0c0 .. m_r2c2 from the lowest bit up
  logic [NUM_ENT*OUT_W-1:0] out_tdata;
  // zero_input
  logic out_tuser;

  quat_to_rotation_matrix_core #(.IN_WIDTH(IN_W), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  rot_t expected_mats[$];
  int mismatches = 0;
  int matrices_seen = 0;
  int quats_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_receiver = 0;
  bit timed_out = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Round 2x-scaled quotient to nearest, ties away; saturate to one.
  function automatic ent_t scaled_entry(longint num, longint n, int extra);
    longint mag;
    longint q2;
    longint one;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    one = longint'(1) << FB;
    q2 = (mag <<< (FB + extra)) / n;
    q2 = (q2 + 1) >>> 1;
    if (q2 > one) q2 = one;
    if (neg) q2 = -q2;
    return ent_t'(q2[OUT_W-1:0]);
  endfunction

  function automatic rot_t rotation_of(quat_t q);
    rot_t r;
    longint w, x, y, z, ww, xx, yy, zz, n;
    w = q.qw; x = q.qx; y = q.qy; z = q.qz;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n = ww + xx + yy + zz;
    r.zero = (n == 0);
    r.m = '0;
    if (n != 0) begin
      // numerators stay below 2^33, so the shift by FB+2 fits in 64 bits
      r.m[0] = scaled_entry(ww + xx - yy - zz, n, 1);
      r.m[1] = scaled_entry(x * y - w * z, n, 2);
      r.m[2] = scaled_entry(x * z + w * y, n, 2);
      r.m[3] = scaled_entry(x * y + w * z, n, 2);
      r.m[4] = scaled_entry(ww - xx + yy - zz, n, 1);
      r.m[5] = scaled_entry(y * z - w * x, n, 2);
      r.m[6] = scaled_entry(x * z - w * y, n, 2);
      r.m[7] = scaled_entry(y * z + w * x, n, 2);
      r.m[8] = scaled_entry(ww - xx - yy + zz, n, 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Drive one quaternion and hold it until accepted; valid stays high for
  // a following item and drops while the sender idles.
  task automatic send_quat(quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= q;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_mats.push_back(rotation_of(q));
    quats_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return IN_W'($urandom_range(7) - 4);
      3: return IN_W'($urandom_range(511) - 256);
      default: return IN_W'($urandom());
    endcase
  endfunction

  // Receiver: random stalls plus a forced hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted matrix with the oldest expectation.
  always @(posedge clk) begin
    rot_t want;
    ent_t got;
    if (rst_n && out_tvalid && out_tready) begin
      matrices_seen++;
      if (expected_mats.size() == 0) begin
        $display("unexpected matrix at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_mats.pop_front();
        for (int i = 0; i < NUM_ENT; i++) begin
          got = out_tdata[i*OUT_W +: OUT_W];
          if (got !== want.m[i]) report_mismatch($sformatf("entry %0d", i), got, want.m[i]);
        end
        if (out_tuser !== want.zero) report_mismatch("zero flag", out_tuser, want.zero);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    quat_t q;
    send_quat('{qz: 0, qy: 0, qx: 0, qw: 0});
    send_quat('{qz: 0, qy: 0, qx: 0, qw: 1});
    send_quat('{qz: 0, qy: 0, qx: 0, qw: 16'sh7fff});
    send_quat('{qz: 0, qy: 0, qx: 0, qw: 16'sh8000});
    send_quat('{qz: 0, qy: 0, qx: 16'sh8000, qw: 0});
    send_quat('{qz: 0, qy: 16'sh7fff, qx: 0, qw: 0});
    send_quat('{qz: 16'sh8000, qy: 0, qx: 0, qw: 0});
    send_quat('{qz: 16'sh8000, qy: 16'sh8000, qx: 16'sh8000, qw: 16'sh8000});
    send_quat('{qz: 16'sh7fff, qy: 16'sh7fff, qx: 16'sh7fff, qw: 16'sh7fff});
    send_quat('{qz: 16'sh8000, qy: 16'sh7fff, qx: 16'sh8000, qw: 16'sh7fff});
    send_quat('{qz: 1, qy: -1, qx: 1, qw: -1});
    send_quat('{qz: 0, qy: 0, qx: 1, qw: 1});
    send_quat('{qz: 3, qy: 0, qx: 0, qw: 1});
    send_quat('{qz: -1, qy: 2, qx: 3, qw: 5});
    send_quat('{qz: 16'sh5555, qy: 16'shaaaa, qx: 16'sh5555, qw: 16'shaaaa});
    q = '1;
    send_quat(q);
    wait_drained();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    quat_t q;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      q.qw = rand_comp(); q.qx = rand_comp(); q.qy = rand_comp(); q.qz = rand_comp();
      send_quat(q);
    end
    wait_drained();
  endtask

  // Hold the receiver off so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    quat_t q;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 2 * LATENCY; i++) begin
        q = {$urandom(), $urandom()};
        send_quat(q);
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 60, 0);
    test_random(350, 0, 60);
    test_random(350, 28, 28);
    test_backpressure();
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d quaternions, %0d matrices checked, idle/stall phases and a full stall",
             quats_sent, matrices_seen);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/q2r_pkg.sv
rtl/core/q2r_prod.sv
rtl/core/q2r_div_stage.sv
rtl/core/quat_to_rotation_matrix_core.sv
sim/tb_quat_to_rotation_matrix_core.sv
